FILE: design/stl_pkg.sv
// shared constants, character codes, keyword table and transaction types for the token lexer
package stl_pkg;

   localparam int MaxIdent  = 16;
   localparam int IdentIdxW = $clog2(MaxIdent);
   localparam int RspDepth  = 4;
   localparam int RspPtrW   = $clog2(RspDepth);
   localparam int RspCntW   = $clog2(RspDepth + 1);

   localparam logic [30:0] VMax = 31'h7FFF_FFFF;

   // lexer modes
   localparam logic [2:0] ModeIdle    = 3'd0;
   localparam logic [2:0] ModeIdent   = 3'd1;
   localparam logic [2:0] ModeDec     = 3'd2;
   localparam logic [2:0] ModeOct     = 3'd3;
   localparam logic [2:0] ModeHex     = 3'd4;
   localparam logic [2:0] ModeComment = 3'd5;
   localparam logic [2:0] ModeOp      = 3'd6;

   // token kinds
   localparam logic [4:0] KindEnd   = 5'd0;
   localparam logic [4:0] KindIdent = 5'd1;
   localparam logic [4:0] KindNum   = 5'd2;
   localparam logic [4:0] KindKw0   = 5'd3;
   localparam logic [4:0] KindLe    = 5'd19;
   localparam logic [4:0] KindGe    = 5'd20;
   localparam logic [4:0] KindAssign = 5'd21;
   localparam logic [4:0] KindNe    = 5'd22;
   localparam logic [4:0] KindOr    = 5'd23;
   localparam logic [4:0] KindChar  = 5'd24;

   // character codes
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChBang   = 8'h21;
   localparam logic [7:0] ChHash   = 8'h23;
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChAmp    = 8'h26;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChSeven  = 8'h37;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChColon  = 8'h3A;
   localparam logic [7:0] ChLt     = 8'h3C;
   localparam logic [7:0] ChEq     = 8'h3D;
   localparam logic [7:0] ChGt     = 8'h3E;
   localparam logic [7:0] ChUpA    = 8'h41;
   localparam logic [7:0] ChUpF    = 8'h46;
   localparam logic [7:0] ChUpZ    = 8'h5A;
   localparam logic [7:0] ChLowA   = 8'h61;
   localparam logic [7:0] ChLowF   = 8'h66;
   localparam logic [7:0] ChLowZ   = 8'h7A;
   localparam logic [7:0] ChBar    = 8'h7C;

   // keywords, first character in the low byte
   localparam logic [127:0] KwText [16] = '{
      128'("noitcnuf"), 128'("margorp"), 128'("nigeb"), 128'("dne"),
      128'("regetni"), 128'("tixe"), 128'("fi"), 128'("neht"),
      128'("esle"), 128'("rof"), 128'("ot"), 128'("od"),
      128'("rav"), 128'("tsnoc"), 128'("otnwod"), 128'("erudecorp")
   };

   localparam logic [4:0] KwLen [16] = '{
      5'd8, 5'd7, 5'd5, 5'd3, 5'd7, 5'd4, 5'd2, 5'd4,
      5'd4, 5'd3, 5'd2, 5'd2, 5'd3, 5'd5, 5'd6, 5'd9
   };

   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  char_code;
      logic [30:0] number;
      logic [63:0] ident_low;
      logic [63:0] ident_high;
      logic [4:0]  ident_length;
      logic        truncated;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    entry0;
      rsp_type    entry1;
   } push_type;

endpackage

FILE: design/stl_ifs.sv
// valid/ready channel interfaces for source bytes and tokens
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_req;
   logic       end_of_input;

   modport source (output valid, byte_req, end_of_input, input ready);
   modport sink (input valid, byte_req, end_of_input, output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  kind;
   logic [7:0]  char_code;
   logic [30:0] number;
   logic [63:0] ident_low;
   logic [63:0] ident_high;
   logic [4:0]  ident_length;
   logic        truncated;
   logic        overflow;
   logic        last;

   modport source (output valid, kind, char_code, number, ident_low, ident_high,
                   ident_length, truncated, overflow, last, input ready);
   modport sink (input valid, kind, char_code, number, ident_low, ident_high,
                 ident_length, truncated, overflow, last, output ready);
endinterface

FILE: design/stl_core.sv
// lexer state and per-byte token logic, up to two tokens per accepted byte
module stl_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          byte_req,
   input  logic                end_of_input,
   output stl_pkg::push_type   push
);

   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  store_ff [stl_pkg::MaxIdent];
   logic [4:0]  count_ff, count_in;
   logic [30:0] acc_ff, acc_in;
   logic        stopped_ff, stopped_in;
   logic        sat_ff, sat_in;
   logic [7:0]  pending_ff, pending_in;
   logic        overlong_ff, overlong_in;

   logic                           store_we;
   logic [stl_pkg::IdentIdxW-1:0]  store_idx;

   logic        is_space, is_digit, is_alpha, is_alnum, is_op_start, is_hex;
   logic [3:0]  hex_d;
   logic [35:0] acc_wide, acc_scaled, acc_sum;
   logic [3:0]  dig;
   logic        acc_ovf;
   logic        stop;
   logic [127:0] ident_bits;
   logic [4:0]  op_k;

   stl_pkg::rsp_type ident_tok, num_tok, pre_tok, post_tok;
   logic             pre_valid, post_valid, do_fresh;

   always_comb begin
      is_space = (byte_req == stl_pkg::ChSpace) ||
                 (byte_req >= stl_pkg::ChTab && byte_req <= stl_pkg::ChCr);
      is_digit = byte_req inside {[stl_pkg::ChZero:stl_pkg::ChNine]};
      is_alpha = byte_req inside {[stl_pkg::ChLowA:stl_pkg::ChLowZ],
                                  [stl_pkg::ChUpA:stl_pkg::ChUpZ]};
      is_alnum = is_alpha || is_digit;
      is_op_start = byte_req inside {stl_pkg::ChBang, stl_pkg::ChColon, stl_pkg::ChBar,
                                     [stl_pkg::ChLt:stl_pkg::ChGt]};
      is_hex = is_digit || byte_req inside {[stl_pkg::ChLowA:stl_pkg::ChLowF],
                                            [stl_pkg::ChUpA:stl_pkg::ChUpF]};
      hex_d = is_digit ? byte_req[3:0] : 4'(byte_req[3:0] + 4'd9);
   end

   // accumulator step: value * base + digit
   always_comb begin
      acc_wide = {5'd0, acc_ff};
      case (mode_ff)
         stl_pkg::ModeDec: begin
            acc_scaled = (acc_wide << 3) + (acc_wide << 1);
            dig = byte_req[3:0];
         end
         stl_pkg::ModeOct: begin
            acc_scaled = acc_wide << 3;
            dig = byte_req[3:0];
         end
         default: begin
            acc_scaled = acc_wide << 4;
            dig = hex_d;
         end
      endcase
      acc_sum = acc_scaled + {32'd0, dig};
      acc_ovf = acc_sum > {5'd0, stl_pkg::VMax};
   end

   // pending identifier and number tokens from the current state
   always_comb begin
      for (int i = 0; i < stl_pkg::MaxIdent; i++) begin
         ident_bits[8*i +: 8] = (5'(i) < count_ff) ? store_ff[i] : 8'd0;
      end
      ident_tok = '0;
      ident_tok.kind = stl_pkg::KindIdent;
      ident_tok.ident_low = ident_bits[63:0];
      ident_tok.ident_high = ident_bits[127:64];
      ident_tok.ident_length = count_ff;
      ident_tok.truncated = overlong_ff;
      for (int k = 15; k >= 0; k--) begin
         if (!overlong_ff && count_ff == stl_pkg::KwLen[k] &&
             ident_bits == stl_pkg::KwText[k]) begin
            ident_tok.kind = 5'(stl_pkg::KindKw0 + 5'(k));
         end
      end
      num_tok = '0;
      num_tok.kind = stl_pkg::KindNum;
      num_tok.number = acc_ff;
      num_tok.overflow = sat_ff;
   end

   always_comb begin
      if (pending_ff == stl_pkg::ChLt && byte_req == stl_pkg::ChEq) begin
         op_k = stl_pkg::KindLe;
      end else if (pending_ff == stl_pkg::ChGt && byte_req == stl_pkg::ChEq) begin
         op_k = stl_pkg::KindGe;
      end else if (pending_ff == stl_pkg::ChColon && byte_req == stl_pkg::ChEq) begin
         op_k = stl_pkg::KindAssign;
      end else if (pending_ff == stl_pkg::ChBang && byte_req == stl_pkg::ChEq) begin
         op_k = stl_pkg::KindNe;
      end else if (pending_ff == stl_pkg::ChBar && byte_req == stl_pkg::ChBar) begin
         op_k = stl_pkg::KindOr;
      end else begin
         op_k = stl_pkg::KindEnd;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      count_in = count_ff;
      acc_in = acc_ff;
      stopped_in = stopped_ff;
      sat_in = sat_ff;
      pending_in = pending_ff;
      overlong_in = overlong_ff;
      store_we = 1'b0;
      store_idx = count_ff[stl_pkg::IdentIdxW-1:0];
      pre_valid = 1'b0;
      pre_tok = '0;
      post_valid = 1'b0;
      post_tok = '0;
      do_fresh = 1'b0;
      stop = stopped_ff;

      if (end_of_input) begin
         case (mode_ff)
            stl_pkg::ModeIdent: begin
               pre_valid = 1'b1;
               pre_tok = ident_tok;
            end
            stl_pkg::ModeDec, stl_pkg::ModeOct, stl_pkg::ModeHex: begin
               pre_valid = 1'b1;
               pre_tok = num_tok;
            end
            stl_pkg::ModeOp: begin
               pre_valid = 1'b1;
               pre_tok.kind = stl_pkg::KindChar;
               pre_tok.char_code = pending_ff;
            end
            default: begin
               pre_valid = 1'b0;
            end
         endcase
         post_valid = 1'b1;
         post_tok.kind = stl_pkg::KindEnd;
         mode_in = stl_pkg::ModeIdle;
      end else begin
         case (mode_ff)
            stl_pkg::ModeIdent: begin
               if (is_alnum) begin
                  if (count_ff < 5'(stl_pkg::MaxIdent)) begin
                     store_we = 1'b1;
                     count_in = 5'(count_ff + 5'd1);
                  end else begin
                     overlong_in = 1'b1;
                  end
               end else begin
                  pre_valid = 1'b1;
                  pre_tok = ident_tok;
                  do_fresh = 1'b1;
               end
            end
            stl_pkg::ModeDec, stl_pkg::ModeOct, stl_pkg::ModeHex: begin
               if ((mode_ff == stl_pkg::ModeHex) ? is_alnum : is_digit) begin
                  if (mode_ff == stl_pkg::ModeOct) begin
                     stop = stopped_ff || (byte_req > stl_pkg::ChSeven);
                  end else if (mode_ff == stl_pkg::ModeHex) begin
                     stop = stopped_ff || !is_hex;
                  end else begin
                     stop = 1'b0;
                  end
                  stopped_in = stop;
                  if (!stop && !sat_ff) begin
                     if (acc_ovf) begin
                        acc_in = stl_pkg::VMax;
                        sat_in = 1'b1;
                     end else begin
                        acc_in = acc_sum[30:0];
                     end
                  end
               end else begin
                  pre_valid = 1'b1;
                  pre_tok = num_tok;
                  do_fresh = 1'b1;
               end
            end
            stl_pkg::ModeComment: begin
               if (byte_req == stl_pkg::ChLf || byte_req == stl_pkg::ChCr) begin
                  mode_in = stl_pkg::ModeIdle;
               end
            end
            stl_pkg::ModeOp: begin
               pre_valid = 1'b1;
               if (op_k != stl_pkg::KindEnd) begin
                  pre_tok.kind = op_k;
                  mode_in = stl_pkg::ModeIdle;
               end else begin
                  pre_tok.kind = stl_pkg::KindChar;
                  pre_tok.char_code = pending_ff;
                  do_fresh = 1'b1;
               end
            end
            default: begin
               do_fresh = 1'b1;
            end
         endcase

         // byte starts a new token
         if (do_fresh) begin
            mode_in = stl_pkg::ModeIdle;
            if (is_space) begin
               mode_in = stl_pkg::ModeIdle;
            end else if (is_alpha) begin
               mode_in = stl_pkg::ModeIdent;
               store_we = 1'b1;
               store_idx = '0;
               count_in = 5'd1;
               overlong_in = 1'b0;
            end else if (is_digit || byte_req == stl_pkg::ChAmp ||
                         byte_req == stl_pkg::ChDollar) begin
               stopped_in = 1'b0;
               sat_in = 1'b0;
               if (is_digit) begin
                  mode_in = stl_pkg::ModeDec;
                  acc_in = {27'd0, byte_req[3:0]};
               end else begin
                  mode_in = (byte_req == stl_pkg::ChAmp) ? stl_pkg::ModeOct
                                                         : stl_pkg::ModeHex;
                  acc_in = '0;
               end
            end else if (byte_req == stl_pkg::ChHash) begin
               mode_in = stl_pkg::ModeComment;
            end else if (is_op_start) begin
               mode_in = stl_pkg::ModeOp;
               pending_in = byte_req;
            end else begin
               post_valid = 1'b1;
               post_tok.kind = stl_pkg::KindChar;
               post_tok.char_code = byte_req;
            end
         end
      end
   end

   always_comb begin
      push.count = accept ? (2'(pre_valid) + 2'(post_valid)) : 2'd0;
      push.entry0 = pre_valid ? pre_tok : post_tok;
      push.entry0.last = !(pre_valid && post_valid);
      push.entry1 = post_tok;
      push.entry1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stl_pkg::ModeIdle;
         count_ff <= '0;
         acc_ff <= '0;
         stopped_ff <= 1'b0;
         sat_ff <= 1'b0;
         pending_ff <= '0;
         overlong_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         count_ff <= count_in;
         acc_ff <= acc_in;
         stopped_ff <= stopped_in;
         sat_ff <= sat_in;
         pending_ff <= pending_in;
         overlong_ff <= overlong_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_we) begin
         store_ff[store_idx] <= byte_req;
      end
   end

endmodule

FILE: design/stl_rsp_fifo.sv
// result queue taking up to two tokens per cycle and releasing one
module stl_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  stl_pkg::push_type  push,
   input  logic               pop,
   output logic               room,
   output logic               head_valid,
   output stl_pkg::rsp_type   head
);

   stl_pkg::rsp_type              entries_ff [stl_pkg::RspDepth];
   logic [stl_pkg::RspPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [stl_pkg::RspPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [stl_pkg::RspCntW-1:0]   count_ff, count_in;
   logic [stl_pkg::RspPtrW-1:0]   wr_ptr_next;

   assign wr_ptr_next = stl_pkg::RspPtrW'(wr_ptr_ff + 1'b1);
   assign room = count_ff <= stl_pkg::RspCntW'(stl_pkg::RspDepth - 2);
   assign head_valid = count_ff != '0;
   assign head = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = stl_pkg::RspPtrW'(wr_ptr_ff + push.count);
      rd_ptr_in = stl_pkg::RspPtrW'(rd_ptr_ff + pop);
      count_in = stl_pkg::RspCntW'(count_ff + push.count - pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.entry1;
      end
   end

endmodule

FILE: design/source_token_lexer.sv
// top level of the source token lexer
// Takes one source byte per clock on the request channel and turns the stream into
// tokens on the response channel. Each accepted byte is lexed in the cycle it is
// taken and yields zero, one or two tokens (a token closed by the byte, then a
// single-character token or the end token); an end_of_input transaction flushes
// the open token and always yields the end token, with last set on the final
// token of every transaction. Tokens wait in a four-entry queue, and a request
// is taken whenever the queue has room for two. A token is written into the queue
// as its byte is taken and is offered from the queue head. A byte that yields two
// tokens leaves the lexer idle, so the next byte yields at most one; with the
// response side always ready the queue never holds more than two tokens and a byte
// is taken every clock. The request channel stalls only while the response side
// holds off.
module source_token_lexer (
   input  logic        clock,
   input  logic        reset,
   stl_req_if.sink     req_chan,
   stl_rsp_if.source   rsp_chan
);

   stl_pkg::push_type push;
   stl_pkg::rsp_type  head;
   logic              room, head_valid, accept, pop;

   assign req_chan.ready = room;
   assign accept = req_chan.valid && room;
   assign pop = head_valid && rsp_chan.ready;

   stl_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_req     (req_chan.byte_req),
      .end_of_input (req_chan.end_of_input),
      .push         (push)
   );

   stl_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .room       (room),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_chan.valid = head_valid;
   assign rsp_chan.kind = head.kind;
   assign rsp_chan.char_code = head.char_code;
   assign rsp_chan.number = head.number;
   assign rsp_chan.ident_low = head.ident_low;
   assign rsp_chan.ident_high = head.ident_high;
   assign rsp_chan.ident_length = head.ident_length;
   assign rsp_chan.truncated = head.truncated;
   assign rsp_chan.overflow = head.overflow;
   assign rsp_chan.last = head.last;

endmodule
